// File: hdl/xpr_pkg.sv
`timescale 1ns / 1ps

package xpr_pkg;

    // Packet geometry
    localparam int unsigned PayloadBytesDefault = 128;
    localparam int unsigned HeaderBytes         = 3;
    localparam int unsigned QueueDepth          = 2;

    // Line codes
    localparam logic [7:0] CODE_SOH = 8'h01;
    localparam logic [7:0] CODE_EOT = 8'h04;
    localparam logic [7:0] CODE_ACK = 8'h06;
    localparam logic [7:0] CODE_NAK = 8'h15;
    localparam logic [7:0] CODE_CAN = 8'h18;
    localparam logic [7:0] SEQ_COMPL_MASK = 8'hFF;

    // Configuration registers
    localparam int unsigned CfgIndexW = 2;
    localparam int unsigned CfgDataW  = 16;
    localparam logic [CfgIndexW-1:0] CFG_TIMEOUT_TICKS = 2'd0;
    localparam logic [CfgIndexW-1:0] CFG_RETRY_LIMIT   = 2'd1;
    localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd3000;
    localparam logic [3:0]  RETRY_LIMIT_RESET   = 4'd3;

    // Request codes on the input channel
    localparam logic [1:0] REQ_BEGIN = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Round outcome reported with every result
    typedef enum logic [2:0] {
        ST_BUSY       = 3'd0,
        ST_ACCEPTED   = 3'd1,
        ST_REJECTED   = 3'd2,
        ST_INCOMPLETE = 3'd3,
        ST_NODATA     = 3'd4,
        ST_END        = 3'd5,
        ST_CANCELLED  = 3'd6
    } t_status;

    // Classified command passed from front to back
    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_BYTE   = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_IGNORE = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
    } t_q_entry;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [6:0] payload_index;
        t_status    status;
    } t_result;

endpackage

// File: hdl/xpr_front.sv
`timescale 1ns / 1ps

module xpr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_req_type,
    input  logic [7:0]         i_rx_byte,
    output logic               o_q_valid,
    input  logic               i_q_pop,
    output xpr_pkg::t_q_entry  o_q_head
);
    import xpr_pkg::*;

    localparam int unsigned PtrW = $clog2(QueueDepth);
    localparam int unsigned CntW = $clog2(QueueDepth + 1);

    t_q_entry            r_mem [QueueDepth];
    logic [PtrW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]     r_count,  n_count;
    t_q_entry            w_entry;
    logic                w_push, w_pop;

    // Classify the request
    always_comb begin
        w_entry.data = i_rx_byte;
        case (i_req_type)
            REQ_BEGIN: w_entry.cmd = CMD_BEGIN;
            REQ_BYTE:  w_entry.cmd = CMD_BYTE;
            REQ_TICK:  w_entry.cmd = CMD_TICK;
            default:   w_entry.cmd = CMD_IGNORE;
        endcase
    end

    assign o_in_ready = (r_count != CntW'(QueueDepth));
    assign o_q_valid  = (r_count != '0);
    assign o_q_head   = r_mem[r_rd_ptr];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_q_pop && o_q_valid;

    // Advance pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the classified transfer
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_entry;
        end
    end

endmodule

// File: hdl/xpr_back.sv
`timescale 1ns / 1ps

module xpr_back #(
    parameter int unsigned PAYLOAD_BYTES = xpr_pkg::PayloadBytesDefault
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [xpr_pkg::CfgIndexW-1:0]   i_cfg_index,
    input  logic [xpr_pkg::CfgDataW-1:0]    i_cfg_data,
    input  logic                            i_q_valid,
    output logic                            o_q_pop,
    input  xpr_pkg::t_q_entry               i_q_head,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output xpr_pkg::t_result                o_result
);
    import xpr_pkg::*;

    localparam int unsigned FrameBytes = PAYLOAD_BYTES + HeaderBytes + 1;
    localparam int unsigned CountW     = $clog2(FrameBytes);

    // Configuration
    logic [15:0]       r_timeout_ticks;
    logic [3:0]        r_retry_limit;

    // Protocol state
    logic              r_reply_ack,  n_reply_ack;
    logic [7:0]        r_expected,   n_expected;
    logic [3:0]        r_retry,      n_retry;
    logic [CountW-1:0] r_byte_count, n_byte_count;
    logic [7:0]        r_sum,        n_sum;
    logic [7:0]        r_first,      n_first;
    logic [7:0]        r_seq,        n_seq;
    logic              r_receiving,  n_receiving;
    logic [15:0]       r_ticks,      n_ticks;

    // Output register
    logic              r_out_valid;
    t_result           r_out, n_out;

    logic              w_step;
    logic [7:0]        w_b;
    logic [7:0]        w_next_seq;
    logic [CountW-1:0] w_data_idx;

    assign w_step     = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop    = w_step;
    assign o_out_valid = r_out_valid;
    assign o_result   = r_out;
    assign w_b        = i_q_head.data;
    assign w_next_seq = r_expected + 8'd1;
    assign w_data_idx = r_byte_count - CountW'(HeaderBytes);

    // Work out one command against the round state
    always_comb begin
        n_reply_ack  = r_reply_ack;
        n_expected   = r_expected;
        n_retry      = r_retry;
        n_byte_count = r_byte_count;
        n_sum        = r_sum;
        n_first      = r_first;
        n_seq        = r_seq;
        n_receiving  = r_receiving;
        n_ticks      = r_ticks;
        n_out        = '0;
        n_out.status = ST_BUSY;

        case (i_q_head.cmd)
            CMD_BEGIN: begin
                if (!r_receiving) begin
                    if (!r_reply_ack && (r_retry >= r_retry_limit)) begin
                        n_out.tx_valid = 1'b1;
                        n_out.tx_byte  = CODE_CAN;
                        n_out.status   = ST_CANCELLED;
                    end else begin
                        n_retry        = r_reply_ack ? 4'd1 : r_retry + 4'd1;
                        n_out.tx_valid = 1'b1;
                        n_out.tx_byte  = r_reply_ack ? CODE_ACK : CODE_NAK;
                        n_receiving    = 1'b1;
                        n_byte_count   = '0;
                        n_sum          = '0;
                        n_ticks        = '0;
                    end
                end
            end
            CMD_BYTE: begin
                if (r_receiving) begin
                    n_byte_count = r_byte_count + 1'b1;
                    if (r_byte_count == '0) begin
                        n_first = w_b;
                        if (w_b == CODE_EOT) begin
                            // sender has nothing more: end the transfer
                            n_retry        = '0;
                            n_expected     = '0;
                            n_reply_ack    = 1'b0;
                            n_receiving    = 1'b0;
                            n_byte_count   = r_byte_count;
                            n_out.tx_valid = 1'b1;
                            n_out.tx_byte  = CODE_ACK;
                            n_out.status   = ST_END;
                        end
                    end else if (r_byte_count == CountW'(1)) begin
                        n_seq = w_b;
                    end else if (r_byte_count == CountW'(2)) begin
                        if ((r_seq ^ w_b) != SEQ_COMPL_MASK) begin
                            n_first = '0;
                        end
                    end else if (r_byte_count < CountW'(FrameBytes - 1)) begin
                        n_out.payload_valid = 1'b1;
                        n_out.payload_byte  = w_b;
                        n_out.payload_index = w_data_idx[6:0];
                        n_sum               = r_sum + w_b;
                    end else begin
                        // checksum byte: judge the packet
                        n_receiving  = 1'b0;
                        n_byte_count = r_byte_count;
                        if ((r_first == CODE_SOH) && (r_seq == w_next_seq)
                                && (r_sum == w_b)) begin
                            n_expected   = w_next_seq;
                            n_reply_ack  = 1'b1;
                            n_out.status = ST_ACCEPTED;
                        end else begin
                            n_reply_ack  = 1'b0;
                            n_out.status = ST_REJECTED;
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (r_receiving) begin
                    n_ticks = r_ticks + 16'd1;
                    if (n_ticks >= r_timeout_ticks) begin
                        n_receiving = 1'b0;
                        n_reply_ack = 1'b0;
                        if (r_byte_count != '0) begin
                            n_out.status = ST_INCOMPLETE;
                        end else begin
                            n_retry      = '0;
                            n_expected   = '0;
                            n_out.status = ST_NODATA;
                        end
                    end
                end
            end
            default: begin
                n_out.status = ST_BUSY;
            end
        endcase
    end

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ticks <= TIMEOUT_TICKS_RESET;
            r_retry_limit   <= RETRY_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data;
                CFG_RETRY_LIMIT:   r_retry_limit   <= i_cfg_data[3:0];
                default:           r_retry_limit   <= r_retry_limit;
            endcase
        end
    end

    // Advance round state on each command taken from the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reply_ack  <= 1'b0;
            r_expected   <= '0;
            r_retry      <= '0;
            r_byte_count <= '0;
            r_sum        <= '0;
            r_first      <= '0;
            r_seq        <= '0;
            r_receiving  <= 1'b0;
            r_ticks      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_step) begin
                r_reply_ack  <= n_reply_ack;
                r_expected   <= n_expected;
                r_retry      <= n_retry;
                r_byte_count <= n_byte_count;
                r_sum        <= n_sum;
                r_first      <= n_first;
                r_seq        <= n_seq;
                r_receiving  <= n_receiving;
                r_ticks      <= n_ticks;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= n_out;
        end
    end

endmodule

// File: hdl/xmodem_packet_receiver_top.sv
`timescale 1ns / 1ps
// An input transfer is written into the queue, then its result is loaded into
// the result register (queue write, then the result register); the result side can stall it.
// Throughput: one item per cycle while the result side does not stall; each item is one round-state update.
// Reset: synchronous, active low; clears the queue, the round state and the
// result valid flag, and loads timeout_ticks 3000 and retry_limit 3.
module xmodem_packet_receiver_top #(
    parameter int unsigned PAYLOAD_BYTES = xpr_pkg::PayloadBytesDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [xpr_pkg::CfgIndexW-1:0]  i_cfg_index,
    input  logic [xpr_pkg::CfgDataW-1:0]   i_cfg_data,
    // input items
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [1:0]                     i_req_type,
    input  logic [7:0]                     i_rx_byte,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_tx_valid,
    output logic [7:0]                     o_tx_byte,
    output logic                           o_payload_valid,
    output logic [7:0]                     o_payload_byte,
    output logic [6:0]                     o_payload_index,
    output logic [2:0]                     o_status
);
    import xpr_pkg::*;

    logic      w_q_valid;
    logic      w_q_pop;
    t_q_entry  w_q_head;
    t_result   w_result;

    assign o_cfg_ready = 1'b1;

    xpr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_req_type (i_req_type),
        .i_rx_byte  (i_rx_byte),
        .o_q_valid  (w_q_valid),
        .i_q_pop    (w_q_pop),
        .o_q_head   (w_q_head)
    );

    xpr_back #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (w_q_valid),
        .o_q_pop     (w_q_pop),
        .i_q_head    (w_q_head),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (w_result)
    );

    // Unpack the result fields
    assign o_tx_valid      = w_result.tx_valid;
    assign o_tx_byte       = w_result.tx_byte;
    assign o_payload_valid = w_result.payload_valid;
    assign o_payload_byte  = w_result.payload_byte;
    assign o_payload_index = w_result.payload_index;
    assign o_status        = w_result.status;

endmodule
